// ===== rtl/gbc_pkg.sv =====
`default_nettype none

package gbc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int COUNT_BITS_DEF  = 20;

	localparam int CAL_BITS     = 31;
	localparam int ELAPSED_BITS = 32;
	localparam int DT_BITS      = 24;
	localparam logic [CAL_BITS-1:0] CAL_RESET = CAL_BITS'(5000000);

	localparam int NUM_AXES = 3;
	localparam int AXIS_X   = 0;
	localparam int AXIS_Y   = 1;
	localparam int AXIS_Z   = 2;

	typedef enum logic {
		ACT_CALIBRATE = 1'b0,
		ACT_CORRECT   = 1'b1
	} action_t;

	typedef struct packed {
		logic load;
		logic cal;
		logic step;
		logic commit;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/gbc_lane.sv =====
`default_nettype none

module gbc_lane #(
	parameter int SAMPLE_BITS = gbc_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = gbc_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS  = gbc_pkg::COUNT_BITS_DEF,
	localparam int MEAN_BITS  = SAMPLE_BITS + FRAC_BITS,
	localparam int DIFF_BITS  = MEAN_BITS + 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  gbc_pkg::lane_ctl_t           ctl,
	input  wire signed [SAMPLE_BITS-1:0] sample,
	input  wire        [COUNT_BITS-1:0]  count,
	output logic signed [DIFF_BITS-1:0]  corr,
	output logic signed [SAMPLE_BITS-1:0] min_val,
	output logic signed [SAMPLE_BITS-1:0] max_val
);

	localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [MEAN_BITS-1:0]   mean_q;
	logic                          neg_q;
	logic [COUNT_BITS-1:0]         div_q;
	logic [COUNT_BITS-1:0]         rem_q;
	logic [DIFF_BITS-1:0]          quo_q;

	logic signed [MEAN_BITS-1:0] in_scaled;
	logic signed [MEAN_BITS-1:0] q_scaled;
	logic signed [DIFF_BITS-1:0] diff;
	logic        [DIFF_BITS-1:0] mag;
	logic        [COUNT_BITS:0]  trial;
	logic                        fits;
	logic        [COUNT_BITS-1:0] rem_nx;
	logic        [DIFF_BITS-1:0] quo_signed;

	always_comb begin
		in_scaled  = MEAN_BITS'(sample) <<< FRAC_BITS;
		q_scaled   = MEAN_BITS'(sample_q) <<< FRAC_BITS;
		diff       = DIFF_BITS'(in_scaled) - DIFF_BITS'(mean_q);
		mag        = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
		trial      = {rem_q, quo_q[DIFF_BITS-1]};
		fits       = (trial >= {1'b0, div_q});
		rem_nx     = fits ? COUNT_BITS'(trial - {1'b0, div_q}) : trial[COUNT_BITS-1:0];
		quo_signed = neg_q ? DIFF_BITS'(-quo_q) : quo_q;
		corr       = DIFF_BITS'(q_scaled) - DIFF_BITS'(mean_q);
	end

	assign min_val = min_q;
	assign max_val = max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= MIN_RESET;
			max_q  <= MAX_RESET;
			mean_q <= '0;
		end else begin
			if (ctl.load && ctl.cal) begin
				if (sample < min_q) min_q <= sample;
				if (sample > max_q) max_q <= sample;
			end
			if (ctl.commit)
				mean_q <= mean_q + MEAN_BITS'(quo_signed);
		end
	end

	// restoring divide of |diff| by the sample count, one quotient bit per step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sample_q <= sample;
			if (ctl.cal) begin
				neg_q <= diff[DIFF_BITS-1];
				div_q <= count;
				rem_q <= '0;
				quo_q <= mag;
			end
		end else if (ctl.step) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIFF_BITS-2:0], fits};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gyro_bias_calibrate_and_correct_core.sv =====
// Gyro bias calibration and correction.
// Input beats (in_valid/in_stall) carry an action and one 3-axis sample.
// A calibrate beat, while elapsed time is below calibration_time, adds
// delta_time, bumps the saturating sample count, tracks per-axis min/max
// and folds the sample into the per-axis Q.FRAC_BITS running mean.
// A correct beat subtracts the mean and remaps the axes.
// Every input beat yields one output beat (out_valid/out_stall).
// Three axis lanes run side by side; each owns a bit-serial divider.
// An updating calibrate beat goes from accept through the lane dividers,
// one quotient bit per cycle, then a commit state and the output load.
// Other beats go straight to the output load.
// One item is in work at a time; a new beat is taken the cycle after the
// previous one has reached the output register, even while it is stalled.
// A stalled output holds; the finished next item waits until it drains.
// cfg write beats (cfg_valid/cfg_ready) set calibration_time; write only
// while idle. Reset restores calibration_time, clears time, count and
// means, and sets min/max to their extreme opposite values.
`default_nettype none

module gyro_bias_calibrate_and_correct_core #(
	parameter int SAMPLE_BITS = gbc_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = gbc_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS  = gbc_pkg::COUNT_BITS_DEF,
	localparam int MEAN_BITS  = SAMPLE_BITS + FRAC_BITS,
	localparam int OUT_BITS   = MEAN_BITS + 1
) (
	input  wire                               clk,
	input  wire                               arst_n,

	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [gbc_pkg::CAL_BITS-1:0]       cfg_data,

	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               action,
	input  wire signed [SAMPLE_BITS-1:0]      sample_x,
	input  wire signed [SAMPLE_BITS-1:0]      sample_y,
	input  wire signed [SAMPLE_BITS-1:0]      sample_z,
	input  wire [gbc_pkg::DT_BITS-1:0]        delta_time,

	output logic                              out_valid,
	input  wire                               out_stall,
	output logic signed [OUT_BITS-1:0]        out_x,
	output logic signed [OUT_BITS-1:0]        out_y,
	output logic signed [OUT_BITS-1:0]        out_z,
	output logic                              still_calibrating,
	output logic                              calibrating_now,
	output logic signed [SAMPLE_BITS-1:0]     min_x,
	output logic signed [SAMPLE_BITS-1:0]     min_y,
	output logic signed [SAMPLE_BITS-1:0]     min_z,
	output logic signed [SAMPLE_BITS-1:0]     max_x,
	output logic signed [SAMPLE_BITS-1:0]     max_y,
	output logic signed [SAMPLE_BITS-1:0]     max_z
);

	localparam int STEP_BITS = $clog2(OUT_BITS);
	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(OUT_BITS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMMIT,
		ST_FIN
	} state_t;

	state_t                            state_q;
	logic [STEP_BITS-1:0]              step_q;
	logic [gbc_pkg::CAL_BITS-1:0]      cal_time_q;
	logic [gbc_pkg::ELAPSED_BITS-1:0]  elapsed_q;
	logic [COUNT_BITS-1:0]             count_q;
	gbc_pkg::action_t                  action_q;

	logic                              out_valid_q;
	logic signed [OUT_BITS-1:0]        out_x_q, out_y_q, out_z_q;
	logic                              still_q, now_q;
	logic signed [SAMPLE_BITS-1:0]     min_x_q, min_y_q, min_z_q;
	logic signed [SAMPLE_BITS-1:0]     max_x_q, max_y_q, max_z_q;

	logic                              accept;
	logic                              cal_active;
	logic                              do_cal;
	logic [COUNT_BITS-1:0]             count_nx;
	logic                              out_free;
	gbc_pkg::lane_ctl_t                ctl;

	logic signed [SAMPLE_BITS-1:0]     lane_sample [gbc_pkg::NUM_AXES];
	logic signed [OUT_BITS-1:0]        lane_corr   [gbc_pkg::NUM_AXES];
	logic signed [SAMPLE_BITS-1:0]     lane_min    [gbc_pkg::NUM_AXES];
	logic signed [SAMPLE_BITS-1:0]     lane_max    [gbc_pkg::NUM_AXES];

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign cal_active = (elapsed_q < gbc_pkg::ELAPSED_BITS'(cal_time_q));
	assign do_cal     = (gbc_pkg::action_t'(action) == gbc_pkg::ACT_CALIBRATE) && cal_active;
	assign count_nx   = (count_q == '1) ? count_q : count_q + 1'b1;
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		ctl.load   = accept;
		ctl.cal    = do_cal;
		ctl.step   = (state_q == ST_DIV);
		ctl.commit = (state_q == ST_COMMIT);
	end

	assign lane_sample[gbc_pkg::AXIS_X] = sample_x;
	assign lane_sample[gbc_pkg::AXIS_Y] = sample_y;
	assign lane_sample[gbc_pkg::AXIS_Z] = sample_z;

	for (genvar i = 0; i < gbc_pkg::NUM_AXES; i++) begin : g_lane
		gbc_lane #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.FRAC_BITS   (FRAC_BITS),
			.COUNT_BITS  (COUNT_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sample  (lane_sample[i]),
			.count   (count_nx),
			.corr    (lane_corr[i]),
			.min_val (lane_min[i]),
			.max_val (lane_max[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_time_q <= gbc_pkg::CAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cal_time_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			action_q <= gbc_pkg::action_t'(action);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			elapsed_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (do_cal) begin
							elapsed_q <= elapsed_q + gbc_pkg::ELAPSED_BITS'(delta_time);
							count_q   <= count_nx;
							state_q   <= ST_DIV;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP)
						state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// merge: remap lane corrections (zero for calibrate beats) and gather status into the output beat
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			if (action_q == gbc_pkg::ACT_CORRECT) begin
				out_x_q <= lane_corr[gbc_pkg::AXIS_Y];
				out_y_q <= -lane_corr[gbc_pkg::AXIS_X];
				out_z_q <= lane_corr[gbc_pkg::AXIS_Z];
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
				out_z_q <= '0;
			end
			still_q <= cal_active;
			now_q   <= cal_active && (elapsed_q != '0);
			min_x_q <= lane_min[gbc_pkg::AXIS_X];
			min_y_q <= lane_min[gbc_pkg::AXIS_Y];
			min_z_q <= lane_min[gbc_pkg::AXIS_Z];
			max_x_q <= lane_max[gbc_pkg::AXIS_X];
			max_y_q <= lane_max[gbc_pkg::AXIS_Y];
			max_z_q <= lane_max[gbc_pkg::AXIS_Z];
		end
	end

	assign out_valid         = out_valid_q;
	assign out_x             = out_x_q;
	assign out_y             = out_y_q;
	assign out_z             = out_z_q;
	assign still_calibrating = still_q;
	assign calibrating_now   = now_q;
	assign min_x             = min_x_q;
	assign min_y             = min_y_q;
	assign min_z             = min_z_q;
	assign max_x             = max_x_q;
	assign max_y             = max_y_q;
	assign max_z             = max_z_q;

endmodule

`default_nettype wire
